### design/lcbb_pkg.sv
// ----------------------------------------------------------------------------
// lcbb_pkg
// Shared types and constants for the LRU cache directory with a byte budget.
// ----------------------------------------------------------------------------
`default_nettype none
package lcbb_pkg;
    localparam int NUM_SLOTS = 256;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

    localparam int S_DATA_W  = 168;
    localparam int M_DATA_W  = 224;

    localparam logic [CNT_W-1:0] LIMIT_RESET  = CNT_W'(NUM_SLOTS);
    localparam logic [39:0]      BUDGET_RESET = 40'd268435456;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_MISS     = 3'd1;
    localparam logic [2:0] ST_INSERTED = 3'd2;
    localparam logic [2:0] ST_PRESENT  = 3'd3;
    localparam logic [2:0] ST_ZERO     = 3'd4;
    localparam logic [2:0] ST_REMOVED  = 3'd5;
    localparam logic [2:0] ST_CLEARED  = 3'd6;

    localparam logic CFG_LIMIT  = 1'b0;
    localparam logic CFG_BUDGET = 1'b1;

    typedef struct packed {
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic [31:0] size;
        logic [31:0] stamp;
        logic [31:0] uses;
    } entry_t;

    typedef struct packed {
        logic       ld_op;
        logic       scan_start;
        logic       scan_oldest;
        logic       hit_wr;
        logic       miss_cnt;
        logic       drop;
        logic       evict;
        logic       install;
        logic       clear;
        logic       respond;
        logic [2:0] status;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       size_zero;
        logic       scan_done;
        logic       found;
        logic       over_budget;
        logic       need_evict;
        logic       full;
        logic       empty;
    } stat_t;
endpackage
`default_nettype wire

### design/lcbb_dpath.sv
// ----------------------------------------------------------------------------
// lcbb_dpath
// Slot memory, valid bits, scan engine, tallies and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module lcbb_dpath (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire  [lcbb_pkg::S_DATA_W-1:0]       s_tdata,
    input  wire                                 cfg_wr_en,
    input  wire                                 cfg_index,
    input  wire  [39:0]                         cfg_wr_data,
    input  lcbb_pkg::cmd_t                      cmd,
    output lcbb_pkg::stat_t                     stat,
    output logic [lcbb_pkg::M_DATA_W-1:0]       m_tdata
);
    localparam int SW = lcbb_pkg::SLOT_W;
    localparam int CW = lcbb_pkg::CNT_W;

    lcbb_pkg::entry_t mem [lcbb_pkg::NUM_SLOTS];
    lcbb_pkg::entry_t rd_reg;
    lcbb_pkg::entry_t wr_entry;
    logic [SW-1:0]    wr_addr;

    logic [1:0]   op_reg;
    logic [63:0]  khi_reg, klo_reg;
    logic [31:0]  isz_reg;
    logic [CW-1:0] lim_reg;
    logic [39:0]  budget_reg;
    logic [lcbb_pkg::NUM_SLOTS-1:0] valid_reg;
    logic [CW-1:0] count_reg, evnow_reg;
    logic [40:0]  total_reg, freed_reg;
    logic [31:0]  clock_reg, hits_reg, misses_reg, evicts_reg;
    logic [31:0]  fsize_reg, fuses_reg;
    logic [CW-1:0] issue_idx_reg;
    logic         issue_on_reg, cmp_on_reg, done_reg, oldest_reg;
    logic [SW-1:0] cmp_idx_reg;
    logic         found_reg, free_found_reg, best_found_reg;
    logic [SW-1:0] m_idx_reg, free_idx_reg, best_idx_reg;
    logic [31:0]  m_size_reg, m_uses_reg, best_stamp_reg, best_size_reg;

    logic [CW-1:0] eff_lim;
    logic [31:0]   uses_inc;
    logic          cmp_valid;

    always_comb begin
        if (lim_reg == '0) begin
            eff_lim = CW'(1);
        end else if (lim_reg > CW'(lcbb_pkg::NUM_SLOTS)) begin
            eff_lim = CW'(lcbb_pkg::NUM_SLOTS);
        end else begin
            eff_lim = lim_reg;
        end
    end

    assign uses_inc  = (m_uses_reg == 32'hFFFF_FFFF) ? m_uses_reg : m_uses_reg + 32'd1;
    assign cmp_valid = cmp_on_reg && valid_reg[cmp_idx_reg];

    assign stat.op          = op_reg;
    assign stat.size_zero   = (isz_reg == '0);
    assign stat.scan_done   = done_reg;
    assign stat.found       = found_reg;
    assign stat.over_budget = ({1'b0, total_reg} + {10'd0, isz_reg}) > {2'b0, budget_reg};
    assign stat.full        = (count_reg >= eff_lim);
    assign stat.need_evict  = (freed_reg < {9'd0, isz_reg}) || stat.full;
    assign stat.empty       = (count_reg == '0);

    always_comb begin
        if (cmd.install) begin
            wr_addr  = free_idx_reg;
            wr_entry = '{key_hi: khi_reg, key_lo: klo_reg, size: isz_reg,
                         stamp: clock_reg + 32'd1, uses: 32'd0};
        end else begin
            wr_addr  = m_idx_reg;
            wr_entry = '{key_hi: khi_reg, key_lo: klo_reg, size: m_size_reg,
                         stamp: clock_reg + 32'd1, uses: uses_inc};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.hit_wr || cmd.install) begin
            mem[wr_addr] <= wr_entry;
        end
        rd_reg <= mem[issue_idx_reg[SW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg        <= lcbb_pkg::LIMIT_RESET;
            budget_reg     <= lcbb_pkg::BUDGET_RESET;
            valid_reg      <= '0;
            count_reg      <= '0;
            total_reg      <= '0;
            clock_reg      <= '0;
            hits_reg       <= '0;
            misses_reg     <= '0;
            evicts_reg     <= '0;
            issue_on_reg   <= 1'b0;
            cmp_on_reg     <= 1'b0;
            done_reg       <= 1'b0;
            issue_idx_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == lcbb_pkg::CFG_LIMIT) begin
                    lim_reg <= cfg_wr_data[CW-1:0];
                end else begin
                    budget_reg <= cfg_wr_data;
                end
            end
            // scan engine
            done_reg   <= cmp_on_reg && (cmp_idx_reg == SW'(lcbb_pkg::NUM_SLOTS - 1));
            cmp_on_reg <= issue_on_reg;
            cmp_idx_reg <= issue_idx_reg[SW-1:0];
            if (cmd.scan_start) begin
                issue_on_reg  <= 1'b1;
                issue_idx_reg <= '0;
                oldest_reg    <= cmd.scan_oldest;
            end else if (issue_on_reg) begin
                issue_idx_reg <= issue_idx_reg + CW'(1);
                if (issue_idx_reg == CW'(lcbb_pkg::NUM_SLOTS - 1)) begin
                    issue_on_reg <= 1'b0;
                end
            end
            if (cmd.scan_start) begin
                found_reg      <= 1'b0;
                best_found_reg <= 1'b0;
                if (!cmd.scan_oldest) begin
                    free_found_reg <= 1'b0;
                end
            end else if (cmp_on_reg) begin
                if (oldest_reg) begin
                    if (cmp_valid && (!best_found_reg || rd_reg.stamp < best_stamp_reg)) begin
                        best_found_reg <= 1'b1;
                        best_idx_reg   <= cmp_idx_reg;
                        best_stamp_reg <= rd_reg.stamp;
                        best_size_reg  <= rd_reg.size;
                    end
                end else begin
                    if (cmp_valid && !found_reg && rd_reg.key_hi == khi_reg
                        && rd_reg.key_lo == klo_reg) begin
                        found_reg  <= 1'b1;
                        m_idx_reg  <= cmp_idx_reg;
                        m_size_reg <= rd_reg.size;
                        m_uses_reg <= rd_reg.uses;
                    end
                    if (!valid_reg[cmp_idx_reg] && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= cmp_idx_reg;
                    end
                end
            end
            // operations
            if (cmd.ld_op) begin
                op_reg    <= s_tdata[1:0];
                khi_reg   <= s_tdata[65:2];
                klo_reg   <= s_tdata[129:66];
                isz_reg   <= s_tdata[161:130];
                evnow_reg <= '0;
                freed_reg <= '0;
                fsize_reg <= '0;
                fuses_reg <= '0;
            end
            if (cmd.hit_wr) begin
                clock_reg <= clock_reg + 32'd1;
                hits_reg  <= hits_reg + 32'd1;
                fsize_reg <= m_size_reg;
                fuses_reg <= uses_inc;
            end
            if (cmd.miss_cnt) begin
                misses_reg <= misses_reg + 32'd1;
            end
            if (cmd.drop) begin
                valid_reg[m_idx_reg] <= 1'b0;
                total_reg <= total_reg - {9'd0, m_size_reg};
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.evict) begin
                valid_reg[best_idx_reg] <= 1'b0;
                total_reg  <= total_reg - {9'd0, best_size_reg};
                count_reg  <= count_reg - CW'(1);
                evicts_reg <= evicts_reg + 32'd1;
                evnow_reg  <= evnow_reg + CW'(1);
                freed_reg  <= freed_reg + {9'd0, best_size_reg};
                if (!free_found_reg || best_idx_reg < free_idx_reg) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= best_idx_reg;
                end
            end
            if (cmd.install) begin
                valid_reg[free_idx_reg] <= 1'b1;
                count_reg <= count_reg + CW'(1);
                total_reg <= total_reg + {9'd0, isz_reg};
                clock_reg <= clock_reg + 32'd1;
            end
            if (cmd.clear) begin
                valid_reg <= '0;
                count_reg <= '0;
                total_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.respond) begin
            m_tdata <= {3'd0, evicts_reg, misses_reg, hits_reg, total_reg[39:0],
                        count_reg, evnow_reg, fuses_reg, fsize_reg, cmd.status};
        end
    end
endmodule
`default_nettype wire

### design/lcbb_ctrl.sv
// ----------------------------------------------------------------------------
// lcbb_ctrl
// Sequencer for lookup, insert with eviction, remove and clear.
// ----------------------------------------------------------------------------
`default_nettype none
module lcbb_ctrl (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire              m_tready,
    input  lcbb_pkg::stat_t  stat,
    output lcbb_pkg::cmd_t   cmd
);
    typedef enum logic [3:0] {
        IDLE, CHECK, KEY_SCAN, EV_DEC, EV_SCAN, LIM_DEC, LIM_SCAN, INSTALL, RESP
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] code_reg, code_next;
    logic       mvalid_reg;

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = mvalid_reg;

    always_comb begin
        cmd        = '0;
        cmd.status = code_reg;
        state_next = state_reg;
        code_next  = code_reg;
        case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    cmd.ld_op  = 1'b1;
                    state_next = CHECK;
                end
            end
            CHECK: begin
                if (stat.op == lcbb_pkg::OP_CLEAR) begin
                    cmd.clear  = 1'b1;
                    code_next  = lcbb_pkg::ST_CLEARED;
                    state_next = RESP;
                end else if (stat.op == lcbb_pkg::OP_INSERT && stat.size_zero) begin
                    code_next  = lcbb_pkg::ST_ZERO;
                    state_next = RESP;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = KEY_SCAN;
                end
            end
            KEY_SCAN: begin
                if (stat.scan_done) begin
                    state_next = RESP;
                    case (stat.op)
                        lcbb_pkg::OP_LOOKUP: begin
                            cmd.hit_wr   = stat.found;
                            cmd.miss_cnt = !stat.found;
                            code_next    = stat.found ? lcbb_pkg::ST_HIT : lcbb_pkg::ST_MISS;
                        end
                        lcbb_pkg::OP_REMOVE: begin
                            cmd.drop  = stat.found;
                            code_next = stat.found ? lcbb_pkg::ST_REMOVED : lcbb_pkg::ST_MISS;
                        end
                        default: begin
                            if (stat.found) begin
                                code_next = lcbb_pkg::ST_PRESENT;
                            end else if (stat.over_budget) begin
                                state_next = EV_DEC;
                            end else begin
                                state_next = LIM_DEC;
                            end
                        end
                    endcase
                end
            end
            EV_DEC: begin
                if (stat.need_evict && !stat.empty) begin
                    cmd.scan_start  = 1'b1;
                    cmd.scan_oldest = 1'b1;
                    state_next      = EV_SCAN;
                end else begin
                    state_next = LIM_DEC;
                end
            end
            EV_SCAN: begin
                if (stat.scan_done) begin
                    cmd.evict  = 1'b1;
                    state_next = EV_DEC;
                end
            end
            LIM_DEC: begin
                if (stat.full && !stat.empty) begin
                    cmd.scan_start  = 1'b1;
                    cmd.scan_oldest = 1'b1;
                    state_next      = LIM_SCAN;
                end else begin
                    state_next = INSTALL;
                end
            end
            LIM_SCAN: begin
                if (stat.scan_done) begin
                    cmd.evict  = 1'b1;
                    state_next = LIM_DEC;
                end
            end
            INSTALL: begin
                cmd.install = 1'b1;
                code_next   = lcbb_pkg::ST_INSERTED;
                state_next  = RESP;
            end
            RESP: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.respond = 1'b1;
                    state_next  = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= IDLE;
            code_reg   <= lcbb_pkg::ST_HIT;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
            if (cmd.respond) begin
                mvalid_reg <= 1'b1;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

### design/lru_cache_with_byte_budget_unit.sv
// ----------------------------------------------------------------------------
// lru_cache_with_byte_budget_unit
// LRU key directory with an entry limit and a byte budget.
// ----------------------------------------------------------------------------
// Steps: clear and zero-size insert need no scan; every other request adds one
//   full slot scan through the single slot memory read port.
// Insert adds one further scan per evicted entry (oldest-stamp search).
// Flow: one request at a time; s_tready is high only while idle.
// Reset: synchronous, active low; clears valid bits, counts and tallies.
`default_nettype none
module lru_cache_with_byte_budget_unit (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // op, key_hi, key_lo, item_size
    input  wire  [lcbb_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // status, found_size, found_uses, evicted_now, entries_held, bytes_held,
    // total_hits, total_misses, total_evictions
    output logic [lcbb_pkg::M_DATA_W-1:0]      m_tdata,
    input  wire                                cfg_wr_en,
    input  wire                                cfg_index,
    input  wire  [39:0]                        cfg_wr_data
);
    lcbb_pkg::cmd_t  cmd;
    lcbb_pkg::stat_t stat;

    lcbb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lcbb_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .m_tdata     (m_tdata)
    );
endmodule
`default_nettype wire

### design/lcbb_checker.sv
// ----------------------------------------------------------------------------
// lcbb_checker
// Port-level checks for the cache directory unit.
// ----------------------------------------------------------------------------
`default_nettype none
module lcbb_checker (
    input wire                            aclk,
    input wire                            aresetn,
    input wire                            s_tvalid,
    input wire                            s_tready,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [lcbb_pkg::M_DATA_W-1:0]   m_tdata
);
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("response valid after reset");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled response changed");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] != 3'd7)
        else $error("bad status code");
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");
    a_entries: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[84:76] <= 9'd256)
        else $error("entry count above slot count");
endmodule

bind lru_cache_with_byte_budget_unit lcbb_checker u_lcbb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the LRU cache directory with a byte budget against a behavioral
// model kept in the bench: directed requests for each operation and corner
// case, then random mixes over a small key pool under several limit and
// budget settings, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module testbench;
    typedef struct packed {
        logic [31:0] total_evictions;
        logic [31:0] total_misses;
        logic [31:0] total_hits;
        logic [39:0] bytes_held;
        logic [8:0]  entries_held;
        logic [8:0]  evicted_now;
        logic [31:0] found_uses;
        logic [31:0] found_size;
        logic [2:0]  status;
    } reply_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [lcbb_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [lcbb_pkg::M_DATA_W-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic cfg_index = 1'b0;
    logic [39:0] cfg_wr_data = '0;

    always #10 aclk = ~aclk;

    lru_cache_with_byte_budget_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    // directory model
    logic [63:0] dir_khi [lcbb_pkg::NUM_SLOTS];
    logic [63:0] dir_klo [lcbb_pkg::NUM_SLOTS];
    logic [31:0] dir_size [lcbb_pkg::NUM_SLOTS];
    logic [31:0] dir_stamp [lcbb_pkg::NUM_SLOTS];
    logic [31:0] dir_uses [lcbb_pkg::NUM_SLOTS];
    bit dir_valid [lcbb_pkg::NUM_SLOTS];
    int unsigned held_count;
    logic [40:0] held_bytes;
    logic [31:0] access_clk, hit_cnt, miss_cnt, evict_cnt;
    logic [8:0] limit_reg;
    logic [39:0] budget_reg;

    reply_t expected_replies[$];
    int errors = 0;
    int replies_seen = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int idle_cycles = 0;
    logic [63:0] key_pool [16];

    function automatic int find_key(logic [63:0] hi, logic [63:0] lo);
        for (int i = 0; i < lcbb_pkg::NUM_SLOTS; i++)
            if (dir_valid[i] && dir_khi[i] == hi && dir_klo[i] == lo) return i;
        return -1;
    endfunction

    function automatic logic [31:0] evict_oldest();
        int best;
        best = -1;
        for (int i = 0; i < lcbb_pkg::NUM_SLOTS; i++)
            if (dir_valid[i] && (best < 0 || dir_stamp[i] < dir_stamp[best])) best = i;
        dir_valid[best] = 0;
        held_bytes -= dir_size[best];
        held_count--;
        evict_cnt++;
        return dir_size[best];
    endfunction

    function automatic reply_t predict_reply(logic [1:0] op, logic [63:0] hi,
                                             logic [63:0] lo, logic [31:0] sz);
        reply_t r;
        int s, lim;
        logic [63:0] freed;
        r = '0;
        case (op)
            lcbb_pkg::OP_LOOKUP: begin
                s = find_key(hi, lo);
                if (s >= 0) begin
                    hit_cnt++;
                    access_clk++;
                    dir_stamp[s] = access_clk;
                    if (dir_uses[s] != 32'hFFFF_FFFF) dir_uses[s]++;
                    r.status = lcbb_pkg::ST_HIT;
                    r.found_size = dir_size[s];
                    r.found_uses = dir_uses[s];
                end else begin
                    miss_cnt++;
                    r.status = lcbb_pkg::ST_MISS;
                end
            end
            lcbb_pkg::OP_INSERT: begin
                if (sz == 0) r.status = lcbb_pkg::ST_ZERO;
                else if (find_key(hi, lo) >= 0) r.status = lcbb_pkg::ST_PRESENT;
                else begin
                    lim = (limit_reg == 0) ? 1 : (limit_reg > lcbb_pkg::NUM_SLOTS ?
                          lcbb_pkg::NUM_SLOTS : int'(limit_reg));
                    if (held_bytes + sz > {1'b0, budget_reg}) begin
                        freed = 0;
                        while ((freed < sz || held_count >= lim) && held_count > 0) begin
                            freed += evict_oldest();
                            r.evicted_now++;
                        end
                    end
                    while (held_count >= lim && held_count > 0) begin
                        void'(evict_oldest());
                        r.evicted_now++;
                    end
                    for (s = 0; s < lcbb_pkg::NUM_SLOTS; s++) if (!dir_valid[s]) break;
                    access_clk++;
                    dir_valid[s] = 1;
                    dir_khi[s] = hi;
                    dir_klo[s] = lo;
                    dir_size[s] = sz;
                    dir_stamp[s] = access_clk;
                    dir_uses[s] = 0;
                    held_count++;
                    held_bytes += sz;
                    r.status = lcbb_pkg::ST_INSERTED;
                end
            end
            lcbb_pkg::OP_REMOVE: begin
                s = find_key(hi, lo);
                if (s >= 0) begin
                    dir_valid[s] = 0;
                    held_bytes -= dir_size[s];
                    held_count--;
                    r.status = lcbb_pkg::ST_REMOVED;
                end else r.status = lcbb_pkg::ST_MISS;
            end
            default: begin
                for (int i = 0; i < lcbb_pkg::NUM_SLOTS; i++) dir_valid[i] = 0;
                held_count = 0;
                held_bytes = 0;
                r.status = lcbb_pkg::ST_CLEARED;
            end
        endcase
        r.entries_held = held_count[8:0];
        r.bytes_held = held_bytes[39:0];
        r.total_hits = hit_cnt;
        r.total_misses = miss_cnt;
        r.total_evictions = evict_cnt;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH reply %0d %s: got %0h want %0h", replies_seen, field, got, want);
        errors++;
    endtask

    task automatic send_request(logic [1:0] op, logic [63:0] hi, logic [63:0] lo,
                                logic [31:0] sz);
        do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, sz, lo, hi, op};
        expected_replies.push_back(predict_reply(op, hi, lo, sz));
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 1'b0;
    endtask

    task automatic write_reg(logic idx, logic [39:0] val);
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == lcbb_pkg::CFG_LIMIT) limit_reg = val[8:0];
        else budget_reg = val;
    endtask

    always @(posedge aclk) begin
        reply_t got, want;
        if (aresetn) m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (m_tvalid && m_tready) begin
            got = m_tdata[$bits(reply_t)-1:0];
            replies_seen++;
            if (expected_replies.size() == 0) begin
                report_mismatch("no request pending", 64'd0, 64'd0);
            end else begin
                want = expected_replies.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.found_size !== want.found_size)
                    report_mismatch("found_size", 64'(got.found_size),
                                    64'(want.found_size));
                if (got.found_uses !== want.found_uses)
                    report_mismatch("found_uses", 64'(got.found_uses),
                                    64'(want.found_uses));
                if (got.evicted_now !== want.evicted_now)
                    report_mismatch("evicted_now", 64'(got.evicted_now),
                                    64'(want.evicted_now));
                if (got.entries_held !== want.entries_held)
                    report_mismatch("entries_held", 64'(got.entries_held),
                                    64'(want.entries_held));
                if (got.bytes_held !== want.bytes_held)
                    report_mismatch("bytes_held", 64'(got.bytes_held),
                                    64'(want.bytes_held));
                if (got.total_hits !== want.total_hits)
                    report_mismatch("total_hits", 64'(got.total_hits),
                                    64'(want.total_hits));
                if (got.total_misses !== want.total_misses)
                    report_mismatch("total_misses", 64'(got.total_misses),
                                    64'(want.total_misses));
                if (got.total_evictions !== want.total_evictions)
                    report_mismatch("total_evictions", 64'(got.total_evictions),
                                    64'(want.total_evictions));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 400000) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic test_operations();
        logic [63:0] ones;
        ones = '1;
        send_request(lcbb_pkg::OP_LOOKUP, ones, ones, 32'd5);
        send_request(lcbb_pkg::OP_REMOVE, 64'h0, 64'h0, 32'd0);
        send_request(lcbb_pkg::OP_INSERT, ones, ones, 32'd0);
        send_request(lcbb_pkg::OP_INSERT, ones, ones, 32'hFFFF_FFFF);
        send_request(lcbb_pkg::OP_INSERT, ones, ones, 32'd7);
        send_request(lcbb_pkg::OP_LOOKUP, ones, ones, 32'd0);
        send_request(lcbb_pkg::OP_LOOKUP, ones, ones, 32'd0);
        send_request(lcbb_pkg::OP_INSERT, 64'h0, 64'h0, 32'd1);
        send_request(lcbb_pkg::OP_INSERT, 64'h0, 64'h1, 32'd2);
        send_request(lcbb_pkg::OP_LOOKUP, 64'h1, 64'h0, 32'd0);
        send_request(lcbb_pkg::OP_REMOVE, 64'h0, 64'h1, 32'd0);
        send_request(lcbb_pkg::OP_REMOVE, 64'h0, 64'h1, 32'd0);
        send_request(lcbb_pkg::OP_CLEAR, ones, ones, 32'd0);
        send_request(lcbb_pkg::OP_LOOKUP, 64'h0, 64'h0, 32'd0);
    endtask

    task automatic test_budget_edges();
        write_reg(lcbb_pkg::CFG_BUDGET, 40'd100);
        write_reg(lcbb_pkg::CFG_LIMIT, 40'd3);
        send_request(lcbb_pkg::OP_INSERT, 64'h10, 64'h1, 32'd40);
        send_request(lcbb_pkg::OP_INSERT, 64'h10, 64'h2, 32'd40);
        send_request(lcbb_pkg::OP_LOOKUP, 64'h10, 64'h1, 32'd0);
        send_request(lcbb_pkg::OP_INSERT, 64'h10, 64'h3, 32'd30);
        send_request(lcbb_pkg::OP_INSERT, 64'h10, 64'h4, 32'd200);
        send_request(lcbb_pkg::OP_INSERT, 64'h10, 64'h5, 32'd1);
        send_request(lcbb_pkg::OP_INSERT, 64'h10, 64'h6, 32'd1);
        send_request(lcbb_pkg::OP_INSERT, 64'h10, 64'h7, 32'd1);
        write_reg(lcbb_pkg::CFG_LIMIT, 40'd1);
        send_request(lcbb_pkg::OP_INSERT, 64'h10, 64'h8, 32'd1);
        write_reg(lcbb_pkg::CFG_LIMIT, 40'd0);
        send_request(lcbb_pkg::OP_INSERT, 64'h10, 64'h9, 32'd1);
        write_reg(lcbb_pkg::CFG_LIMIT, 40'h1FF);
        write_reg(lcbb_pkg::CFG_BUDGET, 40'd1);
        send_request(lcbb_pkg::OP_INSERT, 64'h10, 64'hA, 32'd2);
    endtask

    task automatic test_random_mix(int count, logic [8:0] lim, logic [39:0] budget);
        logic [1:0] op;
        logic [31:0] sz;
        int k;
        write_reg(lcbb_pkg::CFG_LIMIT, 40'(lim));
        write_reg(lcbb_pkg::CFG_BUDGET, budget);
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(15);
            case ($urandom_range(19))
                0: op = lcbb_pkg::OP_CLEAR;
                1, 2, 3: op = lcbb_pkg::OP_REMOVE;
                4, 5, 6, 7, 8, 9, 10, 11: op = lcbb_pkg::OP_LOOKUP;
                default: op = lcbb_pkg::OP_INSERT;
            endcase
            if ($urandom_range(9) == 0) sz = $urandom;
            else if ($urandom_range(19) == 0) sz = 0;
            else sz = $urandom_range(1, 300);
            if ($urandom_range(15) == 0)
                send_request(op, {$urandom, $urandom}, {$urandom, $urandom}, sz);
            else send_request(op, key_pool[k], ~key_pool[k], sz);
        end
    endtask

    initial begin
        for (int i = 0; i < lcbb_pkg::NUM_SLOTS; i++) dir_valid[i] = 0;
        held_count = 0;
        held_bytes = 0;
        access_clk = 0;
        hit_cnt = 0;
        miss_cnt = 0;
        evict_cnt = 0;
        limit_reg = lcbb_pkg::LIMIT_RESET;
        budget_reg = lcbb_pkg::BUDGET_RESET;
        for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_operations();
        test_budget_edges();
        send_idle_pct = 37;
        recv_idle_pct = 68;
        test_random_mix(180, 9'd4, 40'd600);
        send_idle_pct = 68;
        recv_idle_pct = 37;
        test_random_mix(180, 9'd256, 40'hFF_FFFF_FFFF);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(180, 9'd10, 40'd400);
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        $display("Covered %0d replies over all four operations, zero-size and", replies_seen);
        $display("present-key inserts, budget and limit eviction at extreme settings.");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

### lru_cache_with_byte_budget_unit.f
design/lcbb_pkg.sv
design/lcbb_dpath.sv
design/lcbb_ctrl.sv
design/lru_cache_with_byte_budget_unit.sv
design/lcbb_checker.sv
verif/testbench.sv
